// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the RTL of the change-notify throttle (change_notify_throttle_top).
// Each check is sampled at the rising edge of clk and is off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: consequent checked at the edge of the antecedent.
`define CNT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication: consequent checked at the edge that follows the antecedent.
`define CNT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/cnt_pkg.sv =====
// ----------------------------------------------------------------------------
// cnt_pkg
// Widths, codes and constants of the change-notify throttle.
// ----------------------------------------------------------------------------
package cnt_pkg;

  // Observed sources and the index field that selects one
  localparam int SOURCES = 8;
  localparam int SRC_W   = 3;

  // Time, serial and counter widths
  localparam int TIME_W   = 32;
  localparam int SERIAL_W = 32;
  localparam int COUNT_W  = 32;

  // Lower edge of the recheck window in microseconds
  localparam logic [TIME_W-1:0] GRANULE_US = TIME_W'(1000);

  // Register reset values
  localparam logic [TIME_W-1:0] MIN_INTERVAL_RST  = '0;
  localparam logic [TIME_W-1:0] RECHECK_WINDOW_RST = TIME_W'(2200);

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_INTERVAL   = 2'd0,
    REG_RECHECK_WINDOW = 2'd1,
    REG_HAS_SMOOTHERS  = 2'd2,
    REG_UNUSED         = 2'd3
  } cfg_reg_t;

  // Item opcodes
  typedef enum logic {
    OP_COMPARE  = 1'b0,
    OP_EVALUATE = 1'b1
  } op_t;

endpackage

// ===== rtl/cnt_if.sv =====
// ----------------------------------------------------------------------------
// cnt_if
// Valid/ready channels of the change-notify throttle: input and result.
// ----------------------------------------------------------------------------
interface cnt_in_if import cnt_pkg::*; ;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [SRC_W-1:0]    source_index;
  logic [SERIAL_W-1:0] source_serial;
  logic [TIME_W-1:0]   eval_time;
  logic                touch;

  modport source (output valid, opcode, source_index, source_serial, eval_time, touch,
                  input ready);
  modport sink   (input valid, opcode, source_index, source_serial, eval_time, touch,
                  output ready);
endinterface

interface cnt_out_if import cnt_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  fire_time;
  logic [TIME_W-1:0]  fire_interval;
  logic [COUNT_W-1:0] fire_count;

  modport source (output valid, fire_time, fire_interval, fire_count, input ready);
  modport sink   (input valid, fire_time, fire_interval, fire_count, output ready);
endinterface

// ===== rtl/change_notify_throttle_top.sv =====
// ----------------------------------------------------------------------------
// change_notify_throttle_top: an accepted item is held in the stage register; a fire loads the result register.
// Throughput 1 item per cycle while the result slot is free or being taken; a held result stalls the stage.
// Synchronous active-low reset clears serials, flags, times and counters, and loads the register reset values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module change_notify_throttle_top import cnt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  cnt_in_if.sink                in_ch,
  cnt_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // Configuration registers
  logic [TIME_W-1:0] min_interval_r;
  logic [TIME_W-1:0] recheck_window_r;
  logic              has_smoothers_r;

  // Throttle state
  logic [SERIAL_W-1:0] saved_r [SOURCES];
  logic                pending_r, pending_nxt;
  logic                owed_r, owed_nxt;
  logic [TIME_W-1:0]   last_change_r, last_change_nxt;
  logic [TIME_W-1:0]   last_fire_r, last_fire_nxt;
  logic [TIME_W-1:0]   acc_r, acc_nxt;
  logic [COUNT_W-1:0]  fires_r, fires_nxt;

  // Stage register holding the accepted item
  logic                stg_valid_r;
  logic                stg_op_r;
  logic [SRC_W-1:0]    stg_idx_r;
  logic [SERIAL_W-1:0] stg_serial_r;
  logic [TIME_W-1:0]   stg_time_r;
  logic                stg_touch_r;

  // Result register
  logic               out_valid_r;
  logic [TIME_W-1:0]  out_time_r;
  logic [TIME_W-1:0]  out_interval_r;
  logic [COUNT_W-1:0] out_count_r;

  // Datapath signals
  logic              advance;
  logic              cfg_wr;
  cfg_reg_t          cfg_sel;
  logic              is_eval;
  logic              src_ok;
  logic              serial_diff;
  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] since_fire;
  logic [TIME_W:0]   acc_sum;
  logic [TIME_W-1:0] acc_sat;
  logic              in_window;
  logic              attempt;
  logic              try_fire;
  logic              fire;

  // Configuration access
  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[CFG_IDX_W+1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_sel)
      REG_MIN_INTERVAL:   cfg_prdata = CFG_DATA_W'(min_interval_r);
      REG_RECHECK_WINDOW: cfg_prdata = CFG_DATA_W'(recheck_window_r);
      REG_HAS_SMOOTHERS:  cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, has_smoothers_r};
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r   <= MIN_INTERVAL_RST;
      recheck_window_r <= RECHECK_WINDOW_RST;
      has_smoothers_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_MIN_INTERVAL:   min_interval_r   <= cfg_pwdata[TIME_W-1:0];
        REG_RECHECK_WINDOW: recheck_window_r <= cfg_pwdata[TIME_W-1:0];
        REG_HAS_SMOOTHERS:  has_smoothers_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Handshake: the stage moves on when the result slot is free or being taken
  assign advance      = stg_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !stg_valid_r || advance;

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_op_r     <= in_ch.opcode;
      stg_idx_r    <= in_ch.source_index;
      stg_serial_r <= in_ch.source_serial;
      stg_time_r   <= in_ch.eval_time;
      stg_touch_r  <= in_ch.touch;
    end
  end

  // Compare path: detect a new serial
  assign is_eval     = (op_t'(stg_op_r) == OP_EVALUATE);
  assign src_ok      = ({1'b0, stg_idx_r} < (SRC_W+1)'(SOURCES));
  assign serial_diff = src_ok && (saved_r[stg_idx_r] != stg_serial_r);

  // Evaluate path: accumulate, check the window, decide the fire
  assign since_change = stg_time_r - last_change_r;
  assign since_fire   = stg_time_r - last_fire_r;
  assign acc_sum      = {1'b0, acc_r} + {1'b0, since_fire};
  assign acc_sat      = acc_sum[TIME_W] ? {TIME_W{1'b1}} : acc_sum[TIME_W-1:0];
  assign in_window    = (since_change >= GRANULE_US) && (since_change <= recheck_window_r);
  assign attempt      = pending_r || in_window || owed_r;
  assign try_fire     = attempt || stg_touch_r;
  assign fire         = advance && is_eval && try_fire && (acc_sat >= min_interval_r);

  // Next state of the throttle
  always_comb begin
    pending_nxt     = pending_r;
    owed_nxt        = owed_r;
    last_change_nxt = last_change_r;
    last_fire_nxt   = last_fire_r;
    acc_nxt         = acc_r;
    fires_nxt       = fires_r;
    if (advance && !is_eval && serial_diff) begin
      pending_nxt = 1'b1;
      owed_nxt    = has_smoothers_r;
    end
    if (advance && is_eval) begin
      acc_nxt = acc_sat;
      // consume an owed recheck when it alone drives the attempt
      if (!(pending_r || in_window)) begin
        owed_nxt = 1'b0;
      end
      if (try_fire && !fire) begin
        owed_nxt = 1'b1;
      end
      if (fire) begin
        if (pending_r) begin
          last_change_nxt = stg_time_r;
        end
        pending_nxt   = 1'b0;
        acc_nxt       = '0;
        last_fire_nxt = stg_time_r;
        fires_nxt     = fires_r + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r     <= 1'b0;
      owed_r        <= 1'b0;
      last_change_r <= '0;
      last_fire_r   <= '0;
      acc_r         <= '0;
      fires_r       <= '0;
    end else begin
      pending_r     <= pending_nxt;
      owed_r        <= owed_nxt;
      last_change_r <= last_change_nxt;
      last_fire_r   <= last_fire_nxt;
      acc_r         <= acc_nxt;
      fires_r       <= fires_nxt;
    end
  end

  // Store a changed serial
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SOURCES; i++) begin
        saved_r[i] <= '0;
      end
    end else if (advance && !is_eval && serial_diff) begin
      saved_r[stg_idx_r] <= stg_serial_r;
    end
  end

  // Result register: load on fire, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_time_r     <= stg_time_r;
      out_interval_r <= since_fire;
      out_count_r    <= fires_r + COUNT_W'(1);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fire_time     = out_time_r;
  assign out_ch.fire_interval = out_interval_r;
  assign out_ch.fire_count    = out_count_r;

  // Checks on the throttle logic
  `CNT_ASSERT_NEXT(a_fire_count, fire, out_ch.valid && (out_ch.fire_count == fires_r))
  `CNT_ASSERT_NEXT(a_fire_clears, fire, (acc_r == '0) && !pending_r)
  `CNT_ASSERT_NOW(a_empty_ready, !stg_valid_r, in_ch.ready)
  `CNT_ASSERT_NEXT(a_fire_time, fire, last_fire_r == out_ch.fire_time)

endmodule
